// ===== rtl/xec_pkg.sv =====
// ----------------------------------------------------------------------------
// xec_pkg
// Types and constants shared by the extended-precision compare pipeline.
// ----------------------------------------------------------------------------
package xec_pkg;

    // operand classes
    localparam logic [1:0] TAG_VALID = 2'd0;
    localparam logic [1:0] TAG_ZERO  = 2'd1;
    localparam logic [1:0] TAG_INF   = 2'd2;
    localparam logic [1:0] TAG_NAN   = 2'd3;

    // condition codes {c3, c2, c0}
    localparam logic [2:0] CC_GT = 3'd0;
    localparam logic [2:0] CC_LT = 3'd1;
    localparam logic [2:0] CC_EQ = 3'd4;
    localparam logic [2:0] CC_UN = 3'd7;

    // request kinds
    localparam logic REQ_ORDERED   = 1'b0;
    localparam logic REQ_UNORDERED = 1'b1;

    localparam int QUIET_BIT = 62;
    localparam int SIG_W     = 64;
    localparam int HALF_W    = SIG_W / 2;

    typedef struct packed {
        logic              req_type;
        logic              a_empty;
        logic [1:0]        a_tag;
        logic              a_sign;
        logic signed [15:0] a_exp;
        logic [63:0]       a_sig;
        logic              b_empty;
        logic [1:0]        b_tag;
        logic              b_sign;
        logic signed [15:0] b_exp;
        logic [63:0]       b_sig;
    } req_item_t;

    typedef struct packed {
        logic [2:0] cond_codes;
        logic       invalid_raised;
        logic       stack_fault;
        logic       completed;
    } rsp_item_t;

    // after the first stage: classification and partial compares
    typedef struct packed {
        logic       req_type;
        logic       any_empty;
        logic [1:0] a_tag;
        logic [1:0] b_tag;
        logic       a_sign;
        logic       b_sign;
        logic       a_quiet;
        logic       b_quiet;
        logic       exp_eq;
        logic       exp_gt;
        logic       hi_eq;
        logic       hi_gt;
        logic       lo_eq;
        logic       lo_gt;
    } pre_t;

    // after the second stage: merged magnitude compare and nan summary
    typedef struct packed {
        logic       req_type;
        logic       any_empty;
        logic       any_nan;
        logic       any_snan;
        logic [1:0] a_tag;
        logic [1:0] b_tag;
        logic       a_sign;
        logic       b_sign;
        logic       mag_eq;
        logic       mag_gt;
    } mag_t;

endpackage

// ===== rtl/x87_extended_compare.sv =====
// ----------------------------------------------------------------------------
// x87_extended_compare
// Compares two tagged 80-bit extended operands and returns the x87
// condition codes with invalid, stack-fault and completion flags.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one operand pair per
//   item; rsp channel (rsp_valid / rsp_stall / rsp) returns one result item
//   per request, in order.
//   cfg_wr_en / cfg_wr_data write the invalid mask bit; write it only while
//   no item is in flight.
//   An accepted item passes through three register stages before it is
//   presented on rsp; one item per cycle is accepted when the response
//   side does not stall.
//   Stages: operand precompare, magnitude merge, class resolve + output reg.
//   When rsp_stall is high, empty stages still fill, so up to three items
//   are held before req_stall rises; nothing is dropped or repeated.
//   Reset clears all stage valid bits and sets the invalid mask to 1.
// ----------------------------------------------------------------------------
module x87_extended_compare (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  xec_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output xec_pkg::rsp_item_t rsp,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);
    import xec_pkg::*;

    logic invalid_masked_reg;

    logic pre_valid;
    pre_t pre_item;
    logic mag_valid;
    mag_t mag_item;

    logic adv_pre;
    logic adv_mag;
    logic adv_out;

    // a stage loads when it is empty or the stage after it loads
    assign adv_out   = !rsp_valid || !rsp_stall;
    assign adv_mag   = !mag_valid || adv_out;
    assign adv_pre   = !pre_valid || adv_mag;
    assign req_stall = !adv_pre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_masked_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            invalid_masked_reg <= cfg_wr_data;
        end
    end

    xec_precmp u_precmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv_pre),
        .valid_in  (req_valid),
        .item_in   (req),
        .valid_out (pre_valid),
        .pre_out   (pre_item)
    );

    xec_magcmp u_magcmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv_mag),
        .valid_in  (pre_valid),
        .pre_in    (pre_item),
        .valid_out (mag_valid),
        .mag_out   (mag_item)
    );

    xec_resolve u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv_out),
        .valid_in       (mag_valid),
        .mag_in         (mag_item),
        .invalid_masked (invalid_masked_reg),
        .valid_out      (rsp_valid),
        .rsp_out        (rsp)
    );

    a_fault_unordered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stack_fault |-> rsp.cond_codes == CC_UN && rsp.invalid_raised)
        else $error("stack fault without unordered invalid result");

    a_clean_completes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.invalid_raised |-> rsp.completed)
        else $error("result without exception not completed");

    a_invalid_follows_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.invalid_raised |-> rsp.completed == invalid_masked_reg)
        else $error("completed flag does not follow invalid mask");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> pre_valid)
        else $error("accepted item missing from first stage");

endmodule

// ===== rtl/xec_precmp.sv =====
// ----------------------------------------------------------------------------
// xec_precmp
// First stage: exponent compare and split significand compare per half.
// ----------------------------------------------------------------------------
module xec_precmp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_in,
    input  xec_pkg::req_item_t item_in,
    output logic              valid_out,
    output xec_pkg::pre_t     pre_out
);
    import xec_pkg::*;

    logic valid_reg;
    pre_t pre_reg;
    pre_t pre_next;

    always_comb
    begin
        pre_next.req_type  = item_in.req_type;
        pre_next.any_empty = item_in.a_empty | item_in.b_empty;
        pre_next.a_tag     = item_in.a_tag;
        pre_next.b_tag     = item_in.b_tag;
        pre_next.a_sign    = item_in.a_sign;
        pre_next.b_sign    = item_in.b_sign;
        pre_next.a_quiet   = item_in.a_sig[QUIET_BIT];
        pre_next.b_quiet   = item_in.b_sig[QUIET_BIT];
        pre_next.exp_eq    = item_in.a_exp == item_in.b_exp;
        pre_next.exp_gt    = $signed(item_in.a_exp) > $signed(item_in.b_exp);
        pre_next.hi_eq     = item_in.a_sig[SIG_W-1:HALF_W] == item_in.b_sig[SIG_W-1:HALF_W];
        pre_next.hi_gt     = item_in.a_sig[SIG_W-1:HALF_W] > item_in.b_sig[SIG_W-1:HALF_W];
        pre_next.lo_eq     = item_in.a_sig[HALF_W-1:0] == item_in.b_sig[HALF_W-1:0];
        pre_next.lo_gt     = item_in.a_sig[HALF_W-1:0] > item_in.b_sig[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg <= pre_next;
        end
    end

    assign valid_out = valid_reg;
    assign pre_out   = pre_reg;

endmodule

// ===== rtl/xec_magcmp.sv =====
// ----------------------------------------------------------------------------
// xec_magcmp
// Second stage: merges the partial compares into one magnitude result and
// summarizes the nan cases.
// ----------------------------------------------------------------------------
module xec_magcmp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          valid_in,
    input  xec_pkg::pre_t pre_in,
    output logic          valid_out,
    output xec_pkg::mag_t mag_out
);
    import xec_pkg::*;

    logic valid_reg;
    mag_t mag_reg;
    mag_t mag_next;
    logic a_nan;
    logic b_nan;

    always_comb
    begin
        a_nan = pre_in.a_tag == TAG_NAN;
        b_nan = pre_in.b_tag == TAG_NAN;
        mag_next.req_type  = pre_in.req_type;
        mag_next.any_empty = pre_in.any_empty;
        mag_next.any_nan   = a_nan | b_nan;
        mag_next.any_snan  = (a_nan & ~pre_in.a_quiet) | (b_nan & ~pre_in.b_quiet);
        mag_next.a_tag     = pre_in.a_tag;
        mag_next.b_tag     = pre_in.b_tag;
        mag_next.a_sign    = pre_in.a_sign;
        mag_next.b_sign    = pre_in.b_sign;
        mag_next.mag_eq    = pre_in.exp_eq & pre_in.hi_eq & pre_in.lo_eq;
        // exponent first, then upper half, then lower half
        if (!pre_in.exp_eq)
        begin
            mag_next.mag_gt = pre_in.exp_gt;
        end
        else if (!pre_in.hi_eq)
        begin
            mag_next.mag_gt = pre_in.hi_gt;
        end
        else
        begin
            mag_next.mag_gt = pre_in.lo_gt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= mag_next;
        end
    end

    assign valid_out = valid_reg;
    assign mag_out   = mag_reg;

endmodule

// ===== rtl/xec_resolve.sv =====
// ----------------------------------------------------------------------------
// xec_resolve
// Third stage: class-based ordering, exception flags and the output register.
// ----------------------------------------------------------------------------
module xec_resolve (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               valid_in,
    input  xec_pkg::mag_t      mag_in,
    input  logic               invalid_masked,
    output logic               valid_out,
    output xec_pkg::rsp_item_t rsp_out
);
    import xec_pkg::*;

    logic      valid_reg;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;
    logic [2:0] cc_ord;
    logic [2:0] cc_a_sign;
    logic [2:0] cc_b_sign;

    always_comb
    begin
        cc_a_sign = mag_in.a_sign ? CC_LT : CC_GT;
        cc_b_sign = mag_in.b_sign ? CC_GT : CC_LT;

        if (mag_in.a_tag == TAG_ZERO && mag_in.b_tag == TAG_ZERO)
        begin
            cc_ord = CC_EQ;
        end
        else if (mag_in.a_tag == TAG_INF && mag_in.b_tag == TAG_INF)
        begin
            cc_ord = (mag_in.a_sign == mag_in.b_sign) ? CC_EQ : cc_a_sign;
        end
        else if (mag_in.a_tag == TAG_INF)
        begin
            cc_ord = cc_a_sign;
        end
        else if (mag_in.b_tag == TAG_INF || mag_in.a_tag == TAG_ZERO)
        begin
            cc_ord = cc_b_sign;
        end
        else if (mag_in.b_tag == TAG_ZERO || mag_in.a_sign != mag_in.b_sign)
        begin
            cc_ord = cc_a_sign;
        end
        else if (mag_in.mag_eq)
        begin
            cc_ord = CC_EQ;
        end
        else
        begin
            // negative operands reverse the magnitude order
            cc_ord = (mag_in.mag_gt ^ mag_in.a_sign) ? CC_GT : CC_LT;
        end

        rsp_next.cond_codes     = cc_ord;
        rsp_next.invalid_raised = 1'b0;
        rsp_next.stack_fault    = 1'b0;
        rsp_next.completed      = 1'b1;
        if (mag_in.any_empty)
        begin
            rsp_next.cond_codes     = CC_UN;
            rsp_next.invalid_raised = 1'b1;
            rsp_next.stack_fault    = 1'b1;
            rsp_next.completed      = invalid_masked;
        end
        else if (mag_in.any_nan)
        begin
            rsp_next.cond_codes = CC_UN;
            if (mag_in.req_type == REQ_ORDERED || mag_in.any_snan)
            begin
                rsp_next.invalid_raised = 1'b1;
                rsp_next.completed      = invalid_masked;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign valid_out = valid_reg;
    assign rsp_out   = rsp_reg;

endmodule
